// ===== src/akd_pkg.sv =====
// Shared constants, register index codes and reset values for the anchor keypoint decoder.
// No dependencies; the channel interfaces and the core import this package.
package akd_pkg;

   localparam int DATA_W       = 32;
   localparam int ANCHOR_W     = 12;
   localparam int VERTEX_W     = 3;
   localparam int CLASS_OUT_W  = 2;
   localparam int COLOR_OUT_W  = 1;
   localparam int FRAC_W       = 16;
   localparam int VERTEX_COUNT = 5;
   localparam int OBJ_WORD     = 10;
   localparam int COLOR_WORD   = 11;
   localparam int REG_INDEX_W  = 3;

   localparam logic [VERTEX_W-1:0] VERTEX_LAST = VERTEX_W'(VERTEX_COUNT - 1);

   // Stride levels: 8, 16, 32.
   localparam logic [1:0] LEVEL_S8  = 2'd0;
   localparam logic [1:0] LEVEL_S16 = 2'd1;
   localparam logic [1:0] LEVEL_S32 = 2'd2;

   // Configuration register indexes.
   localparam logic [REG_INDEX_W-1:0] REG_SCORE_THRESHOLD = 3'd0;
   localparam logic [REG_INDEX_W-1:0] REG_MAP_XX          = 3'd1;
   localparam logic [REG_INDEX_W-1:0] REG_MAP_XY          = 3'd2;
   localparam logic [REG_INDEX_W-1:0] REG_MAP_X_OFFSET    = 3'd3;
   localparam logic [REG_INDEX_W-1:0] REG_MAP_YX          = 3'd4;
   localparam logic [REG_INDEX_W-1:0] REG_MAP_YY          = 3'd5;
   localparam logic [REG_INDEX_W-1:0] REG_MAP_Y_OFFSET    = 3'd6;

   localparam logic [DATA_W-1:0] THRESHOLD_RESET = 32'd58982;
   localparam logic [DATA_W-1:0] UNITY_Q16       = 32'd65536;

endpackage

// ===== src/akd_if.sv =====
// Valid/ready channel interfaces for tensor words in and vertex items out.
// Depends on akd_pkg for field widths.
interface akd_req_if
   import akd_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] feature_value;
   logic              frame_start;

   modport source (output valid, output feature_value, output frame_start, input ready);
   modport sink   (input valid, input feature_value, input frame_start, output ready);
endinterface

interface akd_rsp_if
   import akd_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [DATA_W-1:0]      vertex_x;
   logic [DATA_W-1:0]      vertex_y;
   logic [VERTEX_W-1:0]    vertex_number;
   logic [CLASS_OUT_W-1:0] class_index;
   logic [COLOR_OUT_W-1:0] color_index;
   logic [DATA_W-1:0]      score;
   logic [ANCHOR_W-1:0]    anchor_number;
   logic                   last;

   modport source (output valid, output vertex_x, output vertex_y, output vertex_number,
                   output class_index, output color_index, output score,
                   output anchor_number, output last, input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input vertex_number,
                   input class_index, input color_index, input score,
                   input anchor_number, input last, output ready);
endinterface

// ===== src/anchor_keypoint_decode_core.sv =====
// Anchor keypoint decoder core: tensor words in, five mapped vertex items per kept anchor out.
// Depends on akd_pkg and the akd_req_if / akd_rsp_if channel interfaces.
//
// Throughput: one tensor word per cycle; the last word of an anchor waits only while the
// previous anchor still has vertices to issue. A kept anchor yields its five vertex items in
// order; the single read-map pipeline issues one vertex per cycle unless the output stalls.
// Vertices pass the job, read-data, grid-point, product and output registers in order.
// Reset (synchronous, active high) clears counters and pipeline valids and restores register
// defaults; the word buffer is not cleared and needs no clearing pass.
module anchor_keypoint_decode_core
   import akd_pkg::*;
#(
   parameter int FRAME_WIDTH  = 416,
   parameter int FRAME_HEIGHT = 416,
   parameter int COLOR_COUNT  = 2,
   parameter int CLASS_COUNT  = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   akd_req_if.sink                req_ch,
   akd_rsp_if.source              rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [REG_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_write_data
);

   // Anchor layout and derived widths.
   localparam int WPA        = 11 + COLOR_COUNT + CLASS_COUNT;
   localparam int CLASS_WORD = COLOR_WORD + COLOR_COUNT;
   localparam int PW         = $clog2(WPA);
   localparam int MEM_DEPTH  = 2 ** (PW + 1);
   localparam int CW         = $clog2(FRAME_WIDTH / 8);
   localparam int RW         = $clog2(FRAME_HEIGHT / 8);
   localparam int GW         = (CW > RW) ? CW : RW;
   localparam int CLW        = (COLOR_COUNT > 1) ? $clog2(COLOR_COUNT) : 1;
   localparam int CSW        = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
   localparam int WIDE_W     = 50;

   localparam logic [CW:0] COLS_S8  = (CW + 1)'(FRAME_WIDTH / 8);
   localparam logic [CW:0] COLS_S16 = (CW + 1)'(FRAME_WIDTH / 16);
   localparam logic [CW:0] COLS_S32 = (CW + 1)'(FRAME_WIDTH / 32);
   localparam logic [RW:0] ROWS_S8  = (RW + 1)'(FRAME_HEIGHT / 8);
   localparam logic [RW:0] ROWS_S16 = (RW + 1)'(FRAME_HEIGHT / 16);
   localparam logic [RW:0] ROWS_S32 = (RW + 1)'(FRAME_HEIGHT / 32);

   // Everything a vertex needs besides its offsets, captured when an anchor completes.
   typedef struct packed {
      logic                bank;
      logic [1:0]          level;
      logic [CW-1:0]       col;
      logic [RW-1:0]       row;
      logic [DATA_W-1:0]   score;
      logic [ANCHOR_W-1:0] anchor;
      logic [CLW-1:0]      color;
      logic [CSW-1:0]      cls;
   } job_type;

   // Saturate a wide signed value to signed 32 bits.
   function automatic logic [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic fits;
      fits = (v[WIDE_W-1:DATA_W-1] == '0) || (v[WIDE_W-1:DATA_W-1] == '1);
      if (fits) begin
         return v[DATA_W-1:0];
      end
      return v[WIDE_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

   // (offset + grid * 2^16) * stride, saturated. The stride is 8 << level.
   function automatic logic [DATA_W-1:0] grid_point(input logic [DATA_W-1:0] off,
                                                    input logic [GW-1:0] grid,
                                                    input logic [1:0] level);
      logic signed [WIDE_W-1:0] base;
      logic signed [WIDE_W-1:0] scaled;
      base   = $signed({{(WIDE_W - DATA_W){off[DATA_W-1]}}, off})
             + $signed({{(WIDE_W - FRAC_W - GW){1'b0}}, grid, {FRAC_W{1'b0}}});
      scaled = base <<< ({1'b0, level} + 3'd3);
      return sat32(scaled);
   endfunction

   // Floor of a Q32.32 product to Q16.16, sign extended to the wide sum width.
   function automatic logic signed [WIDE_W-1:0] floor_q16(input logic signed [63:0] p);
      return $signed({{(WIDE_W - 64 + FRAC_W){p[63]}}, p[63:FRAC_W]});
   endfunction

   //------------------------------------------------------------------------
   // Configuration registers.
   //------------------------------------------------------------------------
   logic [DATA_W-1:0] thr_ff, map_xx_ff, map_xy_ff, map_xo_ff;
   logic [DATA_W-1:0] map_yx_ff, map_yy_ff, map_yo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THRESHOLD_RESET;
         map_xx_ff <= UNITY_Q16;
         map_xy_ff <= '0;
         map_xo_ff <= '0;
         map_yx_ff <= '0;
         map_yy_ff <= UNITY_Q16;
         map_yo_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_SCORE_THRESHOLD: thr_ff    <= csr_write_data;
            REG_MAP_XX:          map_xx_ff <= csr_write_data;
            REG_MAP_XY:          map_xy_ff <= csr_write_data;
            REG_MAP_X_OFFSET:    map_xo_ff <= csr_write_data;
            REG_MAP_YX:          map_yx_ff <= csr_write_data;
            REG_MAP_YY:          map_yy_ff <= csr_write_data;
            REG_MAP_Y_OFFSET:    map_yo_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   //------------------------------------------------------------------------
   // Input side: word position, grid walk and running argmax.
   //------------------------------------------------------------------------
   logic [PW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [1:0]          lvl_ff, lvl_in;
   logic [ANCHOR_W-1:0] anc_ff, anc_in;
   logic                wbank_ff, wbank_in;
   logic [DATA_W-1:0]   obj_ff;
   logic [DATA_W-1:0]   color_best_ff, cls_best_ff;
   logic [CLW-1:0]      color_idx_ff;
   logic [CSW-1:0]      cls_idx_ff;

   logic                job_active_ff, job_active_in;
   logic [VERTEX_W-1:0] job_k_ff, job_k_in;
   job_type             job_ff;
   job_type             job_new;

   logic                adv;
   logic                issue;
   logic                req_accept;
   logic                is_last;
   logic                keep;
   logic                job_launch;

   // A frame start restarts the walk with this very word.
   logic [PW-1:0]       eff_pos;
   logic [CW-1:0]       eff_col;
   logic [RW-1:0]       eff_row;
   logic [1:0]          eff_lvl;
   logic [ANCHOR_W-1:0] eff_anc;
   logic [CW:0]         col_lim, col_inc;
   logic [RW:0]         row_lim, row_inc;

   logic                in_color, in_class, color_take, cls_take;
   logic [CLW-1:0]      cur_color_idx;
   logic [CSW-1:0]      cur_cls_idx;
   logic [CSW-1:0]      cls_idx_final;

   // The last word of an anchor is held back while the previous kept anchor still
   // has vertices to issue; its buffer bank is then still being read.
   assign req_ch.ready = !(job_active_ff && (pos_ff == PW'(WPA - 1)));
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign eff_pos = req_ch.frame_start ? '0 : pos_ff;
   assign eff_col = req_ch.frame_start ? '0 : col_ff;
   assign eff_row = req_ch.frame_start ? '0 : row_ff;
   assign eff_lvl = req_ch.frame_start ? LEVEL_S8 : lvl_ff;
   assign eff_anc = req_ch.frame_start ? '0 : anc_ff;

   assign is_last    = (eff_pos == PW'(WPA - 1));
   assign keep       = ($signed(obj_ff) >= $signed(thr_ff));
   assign job_launch = req_accept && is_last && keep;

   assign in_color      = (eff_pos >= PW'(COLOR_WORD)) && (eff_pos < PW'(CLASS_WORD));
   assign in_class      = (eff_pos >= PW'(CLASS_WORD));
   assign cur_color_idx = CLW'(eff_pos - PW'(COLOR_WORD));
   assign cur_cls_idx   = CSW'(eff_pos - PW'(CLASS_WORD));
   assign color_take    = in_color && ((cur_color_idx == '0) ||
                          ($signed(req_ch.feature_value) > $signed(color_best_ff)));
   assign cls_take      = in_class && ((cur_cls_idx == '0) ||
                          ($signed(req_ch.feature_value) > $signed(cls_best_ff)));
   assign cls_idx_final = cls_take ? cur_cls_idx : cls_idx_ff;

   always_comb begin
      unique case (eff_lvl)
         LEVEL_S16: begin
            col_lim = COLS_S16;
            row_lim = ROWS_S16;
         end
         LEVEL_S32: begin
            col_lim = COLS_S32;
            row_lim = ROWS_S32;
         end
         default: begin
            col_lim = COLS_S8;
            row_lim = ROWS_S8;
         end
      endcase
   end

   assign col_inc = {1'b0, eff_col} + 1'b1;
   assign row_inc = {1'b0, eff_row} + 1'b1;

   always_comb begin
      pos_in   = pos_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      lvl_in   = lvl_ff;
      anc_in   = anc_ff;
      wbank_in = wbank_ff;
      if (req_accept) begin
         col_in = eff_col;
         row_in = eff_row;
         lvl_in = eff_lvl;
         anc_in = eff_anc;
         if (!is_last) begin
            pos_in = eff_pos + 1'b1;
         end else begin
            // Anchor complete: step the grid walk.
            pos_in = '0;
            anc_in = eff_anc + 1'b1;
            if (col_inc >= col_lim) begin
               col_in = '0;
               if (row_inc >= row_lim) begin
                  row_in = '0;
                  if (eff_lvl == LEVEL_S32) begin
                     lvl_in = LEVEL_S8;
                     anc_in = '0;
                  end else begin
                     lvl_in = eff_lvl + 1'b1;
                  end
               end else begin
                  row_in = row_inc[RW-1:0];
               end
            end else begin
               col_in = col_inc[CW-1:0];
            end
            if (keep) begin
               wbank_in = !wbank_ff;
            end
         end
      end
   end

   always_comb begin
      job_new.bank   = wbank_ff;
      job_new.level  = eff_lvl;
      job_new.col    = eff_col;
      job_new.row    = eff_row;
      job_new.score  = obj_ff;
      job_new.anchor = eff_anc;
      job_new.color  = color_idx_ff;
      job_new.cls    = cls_idx_final;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         lvl_ff   <= LEVEL_S8;
         anc_ff   <= '0;
         wbank_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         lvl_ff   <= lvl_in;
         anc_ff   <= anc_in;
         wbank_ff <= wbank_in;
      end
   end

   // Per-anchor scratch values; always written before the anchor uses them.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (eff_pos == PW'(OBJ_WORD)) begin
            obj_ff <= req_ch.feature_value;
         end
         if (color_take) begin
            color_best_ff <= req_ch.feature_value;
            color_idx_ff  <= cur_color_idx;
         end
         if (cls_take) begin
            cls_best_ff <= req_ch.feature_value;
            cls_idx_ff  <= cur_cls_idx;
         end
      end
      if (job_launch) begin
         job_ff <= job_new;
      end
   end

   //------------------------------------------------------------------------
   // Vertex issue: one job at a time, one vertex per advancing cycle.
   //------------------------------------------------------------------------
   assign issue = adv && job_active_ff;

   always_comb begin
      job_active_in = job_active_ff;
      job_k_in      = job_k_ff;
      if (job_launch) begin
         job_active_in = 1'b1;
         job_k_in      = '0;
      end else if (issue) begin
         job_k_in = job_k_ff + 1'b1;
         if (job_k_ff == VERTEX_LAST) begin
            job_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_active_ff <= 1'b0;
         job_k_ff      <= '0;
      end else begin
         job_active_ff <= job_active_in;
         job_k_ff      <= job_k_in;
      end
   end

   //------------------------------------------------------------------------
   // Word buffer: two banks of one anchor each, one write and two reads a cycle.
   //------------------------------------------------------------------------
   logic [DATA_W-1:0] word_mem [MEM_DEPTH];
   logic [PW:0]       waddr, rx_addr, ry_addr;
   logic [DATA_W-1:0] rd_x_ff, rd_y_ff;

   assign waddr   = {wbank_ff, eff_pos};
   assign rx_addr = {job_ff.bank, PW'({job_k_ff, 1'b0})};
   assign ry_addr = {job_ff.bank, PW'({job_k_ff, 1'b1})};

   always_ff @(posedge clock) begin
      if (req_accept) begin
         word_mem[waddr] <= req_ch.feature_value;
      end
      if (adv) begin
         rd_x_ff <= word_mem[rx_addr];
         rd_y_ff <= word_mem[ry_addr];
      end
   end

   //------------------------------------------------------------------------
   // Mapping pipeline: read data, grid point, products, sum into the output register.
   // All stages move together whenever the output register can take an item.
   //------------------------------------------------------------------------
   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [VERTEX_W-1:0] s1_k_ff, s2_k_ff, s3_k_ff;
   job_type             s1_job_ff, s2_job_ff, s3_job_ff;
   logic [DATA_W-1:0]   px_ff, py_ff;
   logic signed [63:0]  prod_xx_ff, prod_xy_ff, prod_yx_ff, prod_yy_ff;
   logic signed [WIDE_W-1:0] sum_x, sum_y;

   logic                   rsp_valid_ff;
   logic [DATA_W-1:0]      rsp_x_ff, rsp_y_ff, rsp_score_ff;
   logic [VERTEX_W-1:0]    rsp_k_ff;
   logic [CLASS_OUT_W-1:0] rsp_class_ff;
   logic [COLOR_OUT_W-1:0] rsp_color_ff;
   logic [ANCHOR_W-1:0]    rsp_anchor_ff;

   assign adv = !rsp_valid_ff || rsp_ch.ready;

   assign sum_x = floor_q16(prod_xx_ff) + floor_q16(prod_xy_ff)
                + $signed({{(WIDE_W - DATA_W){map_xo_ff[DATA_W-1]}}, map_xo_ff});
   assign sum_y = floor_q16(prod_yx_ff) + floor_q16(prod_yy_ff)
                + $signed({{(WIDE_W - DATA_W){map_yo_ff[DATA_W-1]}}, map_yo_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_k_ff   <= job_k_ff;
         s1_job_ff <= job_ff;

         s2_k_ff   <= s1_k_ff;
         s2_job_ff <= s1_job_ff;
         px_ff     <= grid_point(rd_x_ff, GW'(s1_job_ff.col), s1_job_ff.level);
         py_ff     <= grid_point(rd_y_ff, GW'(s1_job_ff.row), s1_job_ff.level);

         s3_k_ff    <= s2_k_ff;
         s3_job_ff  <= s2_job_ff;
         prod_xx_ff <= $signed(map_xx_ff) * $signed(px_ff);
         prod_xy_ff <= $signed(map_xy_ff) * $signed(py_ff);
         prod_yx_ff <= $signed(map_yx_ff) * $signed(px_ff);
         prod_yy_ff <= $signed(map_yy_ff) * $signed(py_ff);

         rsp_x_ff      <= sat32(sum_x);
         rsp_y_ff      <= sat32(sum_y);
         rsp_k_ff      <= s3_k_ff;
         rsp_class_ff  <= CLASS_OUT_W'(s3_job_ff.cls);
         rsp_color_ff  <= s3_job_ff.color[COLOR_OUT_W-1:0];
         rsp_score_ff  <= s3_job_ff.score;
         rsp_anchor_ff <= s3_job_ff.anchor;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.vertex_x      = rsp_x_ff;
   assign rsp_ch.vertex_y      = rsp_y_ff;
   assign rsp_ch.vertex_number = rsp_k_ff;
   assign rsp_ch.class_index   = rsp_class_ff;
   assign rsp_ch.color_index   = rsp_color_ff;
   assign rsp_ch.score         = rsp_score_ff;
   assign rsp_ch.anchor_number = rsp_anchor_ff;
   assign rsp_ch.last          = (rsp_k_ff == VERTEX_LAST);

   //------------------------------------------------------------------------
   // Assertions.
   //------------------------------------------------------------------------
   a_launch_when_free: assert property (@(posedge clock) disable iff (reset)
      job_launch |-> !job_active_ff)
      else $error("anchor job launched while the previous job is still issuing");

   a_bank_separation: assert property (@(posedge clock) disable iff (reset)
      job_active_ff |-> (wbank_ff != job_ff.bank))
      else $error("incoming words target the bank that is being read");

   a_job_ends: assert property (@(posedge clock) disable iff (reset)
      (issue && (job_k_ff == VERTEX_LAST)) |=> !job_active_ff)
      else $error("job stays active after its fifth vertex");

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      job_active_ff |-> (job_k_ff <= VERTEX_LAST))
      else $error("vertex counter out of range");

endmodule
